/* design/min_tracking_stack_core_defines.svh */
// assertion macros for the min tracking stack checker
// no dependencies; included by the checker file
`ifndef MIN_TRACKING_STACK_CORE_DEFINES_SVH
`define MIN_TRACKING_STACK_CORE_DEFINES_SVH

// same-cycle implication, reset disables the check
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/mts_pkg.sv */
// shared types and codes for the min tracking stack
// no dependencies
`default_nettype none

package mts_pkg;

	localparam int unsigned WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_QUERY = 2'd0;
	localparam opcode_t OP_PUSH  = 2'd1;
	localparam opcode_t OP_POP   = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_UNDERFLOW = 2'd1;
	localparam status_t ST_OVERFLOW  = 2'd2;

	// shift command for one row of cells
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctrl_t;

endpackage

`default_nettype wire

/* design/mts_in_if.sv */
// request channel: opcode and value with valid/ready
// depends on mts_pkg
`default_nettype none

interface mts_in_if import mts_pkg::*; ();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	word_t   value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

/* design/mts_out_if.sv */
// result channel: top, minimum, empty flag and status with valid/ready
// depends on mts_pkg
`default_nettype none

interface mts_out_if import mts_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   top_value;
	word_t   min_value;
	logic    is_empty;
	status_t status;

	modport source (output valid, output top_value, output min_value,
		output is_empty, output status, input ready);
	modport sink   (input valid, input top_value, input min_value,
		input is_empty, input status, output ready);
endinterface

`default_nettype wire

/* design/min_tracking_stack_core.sv */
// Min tracking stack: a LIFO of signed 32-bit words that reports its top and its
// running minimum. Each request transfer (query, push or pop) yields exactly one
// result, presented on the result channel the cycle after the request transfer and
// held until it is taken. A new request is taken every clock while the result
// register is free or being drained, so the rate is one item per cycle; a stalled
// result blocks the request side. Both the value stack and the minima stack are rows
// of DEPTH cells that all shift by one place together, which keeps the top
// two entries of each stack in fixed cells. Pop of an empty stack reports underflow,
// push on a full stack reports overflow and is dropped; top and minimum read 0 when
// empty.
// depends on mts_pkg, mts_in_if, mts_out_if and mts_chain
`default_nettype none

module min_tracking_stack_core import mts_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  wire   clk,
	input  wire   arst_n,
	mts_in_if.sink    req,
	mts_out_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [CNT_W-1:0] vcount_q, mcount_q;
	logic [CNT_W-1:0] vcount_nxt, mcount_nxt;

	logic        out_valid_q;
	word_t       top_q, min_q;
	logic        empty_q;
	status_t     status_q;

	word_t       vtop0, vtop1, mtop0, mtop1;
	shift_ctrl_t vctrl, mctrl;

	logic    accept, is_push, is_pop, push_ok, pop_ok, m_push, m_pop;
	word_t   top_nxt, min_nxt;
	status_t status_nxt;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_push   = accept && (req.opcode == OP_PUSH);
	assign is_pop    = accept && (req.opcode == OP_POP);
	assign push_ok   = is_push && (vcount_q != CNT_FULL);
	assign pop_ok    = is_pop && (vcount_q != '0);

	assign m_push = push_ok && ((mcount_q == '0) ||
		((mcount_q != CNT_FULL) && (req.value <= mtop0)));
	assign m_pop  = pop_ok && (mcount_q != '0) && (vtop0 == mtop0);

	assign vctrl = '{push: push_ok, pop: pop_ok};
	assign mctrl = '{push: m_push, pop: m_pop};

	mts_chain #(.DEPTH(DEPTH)) u_values (
		.clk  (clk),
		.ctrl (vctrl),
		.din  (req.value),
		.top0 (vtop0),
		.top1 (vtop1)
	);

	mts_chain #(.DEPTH(DEPTH)) u_minima (
		.clk  (clk),
		.ctrl (mctrl),
		.din  (req.value),
		.top0 (mtop0),
		.top1 (mtop1)
	);

	always_comb begin
		vcount_nxt = vcount_q;
		mcount_nxt = mcount_q;
		top_nxt    = vtop0;
		min_nxt    = mtop0;
		status_nxt = ST_OK;
		if (push_ok) begin
			vcount_nxt = vcount_q + 1'b1;
			top_nxt    = req.value;
		end else if (pop_ok) begin
			vcount_nxt = vcount_q - 1'b1;
			top_nxt    = vtop1;
		end
		if (m_push) begin
			mcount_nxt = mcount_q + 1'b1;
			min_nxt    = req.value;
		end else if (m_pop) begin
			mcount_nxt = mcount_q - 1'b1;
			min_nxt    = mtop1;
		end
		if (is_push && !push_ok) begin
			status_nxt = ST_OVERFLOW;
		end else if (is_pop && !pop_ok) begin
			status_nxt = ST_UNDERFLOW;
		end
		// empty stack reads zero
		if (vcount_nxt == '0) begin
			top_nxt = '0;
			min_nxt = '0;
		end else if (mcount_nxt == '0) begin
			min_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= '0;
			mcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vcount_q <= vcount_nxt;
			mcount_q <= mcount_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= top_nxt;
			min_q    <= min_nxt;
			empty_q  <= (vcount_nxt == '0);
			status_q <= status_nxt;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.top_value = top_q;
	assign rsp.min_value = min_q;
	assign rsp.is_empty  = empty_q;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire

/* design/mts_cell.sv */
// one stack cell: holds a word, shifts down on push and up on pop
// depends on mts_pkg
`default_nettype none

module mts_cell import mts_pkg::*; (
	input  wire         clk,
	input  shift_ctrl_t ctrl,
	input  word_t       from_above,
	input  word_t       from_below,
	output word_t       data
);

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= from_above;
		end else if (ctrl.pop) begin
			data_q <= from_below;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

/* design/mts_chain.sv */
// row of stack cells, cell 0 is the top of stack
// depends on mts_pkg and mts_cell
`default_nettype none

module mts_chain import mts_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  wire         clk,
	input  shift_ctrl_t ctrl,
	input  word_t       din,
	output word_t       top0,
	output word_t       top1
);

	word_t cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t above;
		word_t below;

		if (i == 0) begin : g_first
			assign above = din;
		end else begin : g_mid
			assign above = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign below = cell_data[i];
		end else begin : g_inner
			assign below = cell_data[i+1];
		end

		mts_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_above (above),
			.from_below (below),
			.data       (cell_data[i])
		);
	end

	assign top0 = cell_data[0];
	assign top1 = cell_data[1];

endmodule

`default_nettype wire

/* design/mts_checker.sv */
// port-level checks for min_tracking_stack_core, attached by bind
// depends on mts_pkg and min_tracking_stack_core_defines.svh
`default_nettype none
`include "min_tracking_stack_core_defines.svh"

module mts_checker import mts_pkg::*; (
	input wire     clk,
	input wire     arst_n,
	input wire     req_valid,
	input wire     req_ready,
	input wire     rsp_valid,
	input wire     rsp_ready,
	input word_t   rsp_top_value,
	input word_t   rsp_min_value,
	input wire     rsp_is_empty,
	input status_t rsp_status
);

	// stalled result stays up
	`MTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// every request transfer shows a result next cycle
	`MTS_ASSERT_NEXT(a_req_to_rsp, clk, arst_n, req_valid && req_ready, rsp_valid, "request transfer without result")

	`MTS_ASSERT_NOW(a_empty_zero, clk, arst_n, rsp_valid && rsp_is_empty, (rsp_top_value == '0) && (rsp_min_value == '0), "empty stack reports nonzero top or minimum")

	`MTS_ASSERT_NOW(a_status_flags, clk, arst_n, rsp_valid && ((rsp_status == ST_UNDERFLOW) || (rsp_status == ST_OVERFLOW)), (rsp_status == ST_UNDERFLOW) == rsp_is_empty, "error status disagrees with empty flag")

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_top_value (rsp.top_value),
	.rsp_min_value (rsp.min_value),
	.rsp_is_empty  (rsp.is_empty),
	.rsp_status    (rsp.status)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for min_tracking_stack_core: random bursts of push, pop and query
// transfers checked against a behavioral stack and minima tracker
// depends on mts_pkg, mts_in_if, mts_out_if and the core rtl
module tb;
	import mts_pkg::*;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int ITEM_TARGET = 1450;
	localparam int FULL_ROUND_LEN = 560;
	localparam opcode_t OP_SPARE = 2'd3;

	typedef struct {
		opcode_t op;
		word_t   val;
	} stack_op_t;

	typedef struct {
		word_t   top;
		word_t   mn;
		logic    empty;
		status_t st;
	} stack_view_t;

	logic clk;
	logic arst_n;

	mts_in_if  req_if ();
	mts_out_if rsp_if ();

	min_tracking_stack_core #(.DEPTH(STACK_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted stack contents
	word_t stack_vals [STACK_DEPTH];
	word_t stack_mins [STACK_DEPTH];
	int    val_cnt;
	int    min_cnt;

	stack_op_t   pending_ops [$];
	stack_view_t expected_views [$];
	int          gen_depth;
	int          total_ops;
	int          accepted_ops;
	int          mismatch_count;
	logic        req_fire;

	int burst_left;
	int gap_left;
	int ready_mode;
	int ready_left;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic stack_view_t apply_stack_op(opcode_t op, word_t v);
		stack_view_t r;
		r.st = ST_OK;
		if (op == OP_PUSH) begin
			if (val_cnt >= STACK_DEPTH) begin
				r.st = ST_OVERFLOW;
			end else begin
				if (min_cnt == 0) begin
					stack_mins[0] = v;
					min_cnt = 1;
				end else if (min_cnt < STACK_DEPTH && v <= stack_mins[min_cnt-1]) begin
					stack_mins[min_cnt] = v;
					min_cnt++;
				end
				stack_vals[val_cnt] = v;
				val_cnt++;
			end
		end else if (op == OP_POP) begin
			if (val_cnt == 0) begin
				r.st = ST_UNDERFLOW;
			end else begin
				if (min_cnt > 0 && stack_vals[val_cnt-1] == stack_mins[min_cnt-1])
					min_cnt--;
				val_cnt--;
			end
		end
		r.top   = (val_cnt > 0) ? stack_vals[val_cnt-1] : '0;
		r.mn    = (val_cnt > 0 && min_cnt > 0) ? stack_mins[min_cnt-1] : '0;
		r.empty = (val_cnt == 0);
		return r;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return word_t'(int'($urandom_range(0, 16)) - 8);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic enqueue_op(opcode_t op, word_t v);
		stack_op_t item;
		item.op = op;
		item.val = v;
		pending_ops.push_back(item);
		if (op == OP_PUSH && gen_depth < STACK_DEPTH)
			gen_depth++;
		else if (op == OP_POP && gen_depth > 0)
			gen_depth--;
	endtask

	// fill to full, overflow, drain to empty, underflow
	task automatic full_round();
		int    style;
		word_t cur;
		style = $urandom_range(0, 2);
		cur = rand_word();
		while (gen_depth < STACK_DEPTH) begin
			case (style)
				0: enqueue_op(OP_PUSH, rand_word());
				1: begin
					if ($urandom_range(0, 7) == 0) begin
						enqueue_op(OP_PUSH, rand_word());
					end else begin
						cur = cur - word_t'($urandom_range(0, 2));
						enqueue_op(OP_PUSH, cur);
					end
				end
				default: enqueue_op(OP_PUSH, word_t'(int'($urandom_range(0, 6)) - 3));
			endcase
		end
		repeat ($urandom_range(1, 3)) enqueue_op(OP_PUSH, rand_word());
		enqueue_op(OP_QUERY, word_t'($urandom));
		while (gen_depth > 0) enqueue_op(OP_POP, word_t'($urandom));
		repeat ($urandom_range(1, 2)) enqueue_op(OP_POP, word_t'($urandom));
	endtask

	task automatic random_walk();
		int n;
		int bias;
		int r;
		n = $urandom_range(20, 80);
		bias = $urandom_range(30, 70);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				enqueue_op(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_SPARE, word_t'($urandom));
			else if (r < 10 + bias)
				enqueue_op(OP_PUSH, rand_word());
			else
				enqueue_op(OP_POP, word_t'($urandom));
		end
	endtask

	// nonincreasing pushes then matching pops, grows and shrinks the minima
	task automatic descending_run();
		int    n;
		word_t cur;
		n = $urandom_range(2, 12);
		cur = rand_word();
		repeat (n) begin
			enqueue_op(OP_PUSH, cur);
			cur = cur - word_t'($urandom_range(0, 2));
		end
		repeat (n) enqueue_op(OP_POP, word_t'($urandom));
	endtask

	initial begin
		int rounds_done;
		req_if.valid = 1'b0;
		req_if.opcode = OP_QUERY;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		arst_n = 1'b0;
		val_cnt = 0;
		min_cnt = 0;
		gen_depth = 0;
		accepted_ops = 0;
		mismatch_count = 0;
		req_fire = 1'b0;
		burst_left = 0;
		gap_left = 0;
		ready_mode = 0;
		ready_left = 0;
		rounds_done = 0;

		// directed corners
		enqueue_op(OP_QUERY, '0);
		enqueue_op(OP_POP, 32'sh12345678);
		enqueue_op(OP_SPARE, '1);
		enqueue_op(OP_PUSH, 32'sh7FFFFFFF);
		enqueue_op(OP_PUSH, 32'sh80000000);
		enqueue_op(OP_PUSH, 32'sh80000000);
		enqueue_op(OP_PUSH, '1);
		enqueue_op(OP_PUSH, '0);
		enqueue_op(OP_SPARE, word_t'($urandom));
		enqueue_op(OP_QUERY, word_t'($urandom));
		repeat (5) enqueue_op(OP_POP, word_t'($urandom));
		enqueue_op(OP_POP, '0);
		enqueue_op(OP_PUSH, 32'sd5);
		enqueue_op(OP_PUSH, 32'sd3);
		enqueue_op(OP_PUSH, 32'sd7);
		enqueue_op(OP_PUSH, 32'sd3);
		repeat (4) enqueue_op(OP_POP, word_t'($urandom));

		while (pending_ops.size() < ITEM_TARGET) begin
			if (rounds_done < 2 && ($urandom_range(0, 9) == 0 ||
				pending_ops.size() + (2 - rounds_done) * FULL_ROUND_LEN >= ITEM_TARGET)) begin
				full_round();
				rounds_done++;
			end else if ($urandom_range(0, 3) == 0) begin
				descending_run();
			end else begin
				random_walk();
			end
		end
		total_ops = pending_ops.size();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (accepted_ops < total_ops) @(posedge clk);
		while (expected_views.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// driver: request side in bursts, result side on its own stall pattern
	always @(negedge clk) begin
		stack_op_t item;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				item = pending_ops.pop_front();
				req_if.valid <= 1'b1;
				req_if.opcode <= item.op;
				req_if.value <= item.val;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end

		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(10, 80);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			0: rsp_if.ready <= 1'b1;
			1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
			default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// monitor: predict on request transfer, check on result transfer
	always @(posedge clk) begin
		stack_view_t want;
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req_if.valid && req_if.ready;
			if (req_if.valid && req_if.ready) begin
				expected_views.push_back(apply_stack_op(req_if.opcode, req_if.value));
				accepted_ops++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_views.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_views.pop_front();
					if (rsp_if.top_value !== want.top) begin
						$error("top_value: expected %0d, got %0d", want.top, rsp_if.top_value);
						mismatch_count++;
					end
					if (rsp_if.min_value !== want.mn) begin
						$error("min_value: expected %0d, got %0d", want.mn, rsp_if.min_value);
						mismatch_count++;
					end
					if (rsp_if.is_empty !== want.empty) begin
						$error("is_empty: expected %0b, got %0b", want.empty, rsp_if.is_empty);
						mismatch_count++;
					end
					if (rsp_if.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, rsp_if.status);
						mismatch_count++;
					end
				end
			end
		end
	end

endmodule
